@@ sv/cbz_pkg.sv @@
package cbz_pkg;

  localparam int unsigned FracBits = 24;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned UW       = 25;
  localparam int unsigned SumW     = 64;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [UW-1:0] ufrac_t;
  typedef logic signed [SumW-1:0] sum_t;

  typedef struct packed {
    coord_t query_time;
    coord_t p0_time;
    coord_t p0_value;
    coord_t p1_time;
    coord_t p1_value;
    coord_t p2_time;
    coord_t p2_value;
    coord_t p3_time;
    coord_t p3_value;
  } seg_t;

  typedef struct packed {
    ufrac_t u;
    ufrac_t ot;
  } upar_t;

  typedef struct packed {
    logic [UW-1:0] a3;
    logic [UW+1:0] w1;
    logic [UW+1:0] w2;
    logic [UW-1:0] b3;
  } wts_t;

endpackage

@@ sv/cbz_weights.sv @@
module cbz_weights (
  input  logic           clk,
  input  logic           en,
  input  cbz_pkg::upar_t par_in,
  output cbz_pkg::wts_t  wts_out
);
  import cbz_pkg::*;

  logic [UW-1:0] a2_r, b2_r, u_r, ot_r;
  logic [2*UW-1:0] p_aa, p_bb, p_a3, p_b3, p_w1, p_w2;
  wts_t wts_r;

  assign p_aa = par_in.ot * par_in.ot;
  assign p_bb = par_in.u * par_in.u;

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r <= p_aa[FracBits +: UW];
      b2_r <= p_bb[FracBits +: UW];
      u_r  <= par_in.u;
      ot_r <= par_in.ot;
    end
  end

  assign p_a3 = a2_r * ot_r;
  assign p_b3 = b2_r * u_r;
  assign p_w1 = a2_r * u_r;
  assign p_w2 = ot_r * b2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wts_r.a3 <= p_a3[FracBits +: UW];
      wts_r.b3 <= p_b3[FracBits +: UW];
      wts_r.w1 <= {2'b00, p_w1[FracBits +: UW]} * 27'd3;
      wts_r.w2 <= {2'b00, p_w2[FracBits +: UW]} * 27'd3;
    end
  end

  assign wts_out = wts_r;
endmodule

@@ sv/cbz_dot.sv @@
module cbz_dot (
  input  logic            clk,
  input  logic            en,
  input  cbz_pkg::wts_t   wts,
  input  cbz_pkg::coord_t c0,
  input  cbz_pkg::coord_t c1,
  input  cbz_pkg::coord_t c2,
  input  cbz_pkg::coord_t c3,
  output cbz_pkg::sum_t   sum_out
);
  import cbz_pkg::*;

  logic signed [CoordW+UW+2:0] p0, p1, p2, p3;
  sum_t m0_r, m1_r, m2_r, m3_r, s_r;

  assign p0 = c0 * $signed({1'b0, wts.a3});
  assign p1 = c1 * $signed({1'b0, wts.w1});
  assign p2 = c2 * $signed({1'b0, wts.w2});
  assign p3 = c3 * $signed({1'b0, wts.b3});

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r <= sum_t'(p0);
      m1_r <= sum_t'(p1);
      m2_r <= sum_t'(p2);
      m3_r <= sum_t'(p3);
      s_r  <= (m0_r + m1_r) + (m2_r + m3_r);
    end
  end

  assign sum_out = s_r;
endmodule

@@ sv/cbz_cell.sv @@
module cbz_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_in,
  input  cbz_pkg::seg_t  seg_in,
  input  cbz_pkg::ufrac_t lo_in,
  input  cbz_pkg::ufrac_t hi_in,
  output logic           vld_out,
  output cbz_pkg::seg_t  seg_out,
  output cbz_pkg::ufrac_t lo_out,
  output cbz_pkg::ufrac_t hi_out
);
  import cbz_pkg::*;

  localparam int unsigned Lat = 4;

  ufrac_t mid;
  upar_t  par;
  wts_t   wts;
  sum_t   tsum;
  logic   vld_r [Lat];
  seg_t   seg_r [Lat];
  ufrac_t lo_r  [Lat];
  ufrac_t hi_r  [Lat];
  ufrac_t mid_r [Lat];
  sum_t   target;

  assign mid     = ufrac_t'(({1'b0, lo_in} + {1'b0, hi_in}) >> 1);
  assign par.u   = mid;
  assign par.ot  = ufrac_t'(1 << FracBits) - mid;

  cbz_weights u_wts (.clk(clk), .en(en), .par_in(par), .wts_out(wts));

  cbz_dot u_dot (
    .clk(clk), .en(en), .wts(wts),
    .c0(seg_r[1].p0_time), .c1(seg_r[1].p1_time),
    .c2(seg_r[1].p2_time), .c3(seg_r[1].p3_time),
    .sum_out(tsum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Lat; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_in;
      for (int i = 1; i < Lat; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_r[0] <= seg_in;
      lo_r[0]  <= lo_in;
      hi_r[0]  <= hi_in;
      mid_r[0] <= mid;
      for (int i = 1; i < Lat; i++) begin
        seg_r[i] <= seg_r[i-1];
        lo_r[i]  <= lo_r[i-1];
        hi_r[i]  <= hi_r[i-1];
        mid_r[i] <= mid_r[i-1];
      end
    end
  end

  assign target  = $signed({seg_r[Lat-1].query_time, 32'd0}) >>> (CoordW - FracBits);
  assign vld_out = vld_r[Lat-1];
  assign seg_out = seg_r[Lat-1];
  assign lo_out  = (tsum < target) ? mid_r[Lat-1] : lo_r[Lat-1];
  assign hi_out  = (tsum < target) ? hi_r[Lat-1] : mid_r[Lat-1];
endmodule

@@ sv/cubic_bezier_time_curve_eval.sv @@
// Channel | Direction | Ports
// in      | request   | in_valid, in_stall, in_query_time, in_p0..p3_time/value
// out     | result    | out_valid, out_stall, out_curve_value
// One request is accepted per cycle when the pipeline is not stalled.
// The pipeline runs through BISECT_STEPS bisection cells, then the final value
// evaluation and saturation.
// A stall on the output while out_valid is high freezes the whole pipeline;
// the input stalls only then, and the output register holds its result.
// Reset clears valid bits only.
module cubic_bezier_time_curve_eval #(
  parameter int unsigned BISECT_STEPS = 20
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  cbz_pkg::coord_t in_query_time,
  input  cbz_pkg::coord_t in_p0_time,
  input  cbz_pkg::coord_t in_p0_value,
  input  cbz_pkg::coord_t in_p1_time,
  input  cbz_pkg::coord_t in_p1_value,
  input  cbz_pkg::coord_t in_p2_time,
  input  cbz_pkg::coord_t in_p2_value,
  input  cbz_pkg::coord_t in_p3_time,
  input  cbz_pkg::coord_t in_p3_value,
  output logic            out_valid,
  input  logic            out_stall,
  output cbz_pkg::coord_t out_curve_value
);
  import cbz_pkg::*;

  logic   en;
  logic   vld [BISECT_STEPS+1];
  seg_t   seg [BISECT_STEPS+1];
  ufrac_t lo  [BISECT_STEPS+1];
  ufrac_t hi  [BISECT_STEPS+1];
  ufrac_t mid;
  upar_t  par;
  wts_t   wts;
  sum_t   vsum;
  logic   fv_r [4];
  seg_t   fs_r [2];
  sum_t   sh;
  logic   out_valid_r;
  coord_t out_val_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign vld[0] = in_valid;
  assign seg[0] = '{in_query_time, in_p0_time, in_p0_value, in_p1_time, in_p1_value,
                    in_p2_time, in_p2_value, in_p3_time, in_p3_value};
  assign lo[0]  = '0;
  assign hi[0]  = ufrac_t'(1 << FracBits);

  for (genvar g = 0; g < BISECT_STEPS; g++) begin : g_cell
    cbz_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(vld[g]), .seg_in(seg[g]), .lo_in(lo[g]), .hi_in(hi[g]),
      .vld_out(vld[g+1]), .seg_out(seg[g+1]), .lo_out(lo[g+1]), .hi_out(hi[g+1])
    );
  end

  assign mid    = ufrac_t'(({1'b0, lo[BISECT_STEPS]} + {1'b0, hi[BISECT_STEPS]}) >> 1);
  assign par.u  = mid;
  assign par.ot = ufrac_t'(1 << FracBits) - mid;

  cbz_weights u_wts (.clk(clk), .en(en), .par_in(par), .wts_out(wts));

  cbz_dot u_dot (
    .clk(clk), .en(en), .wts(wts),
    .c0(fs_r[1].p0_value), .c1(fs_r[1].p1_value),
    .c2(fs_r[1].p2_value), .c3(fs_r[1].p3_value),
    .sum_out(vsum)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      fs_r[0] <= seg[BISECT_STEPS];
      fs_r[1] <= fs_r[0];
    end
  end

  assign sh = vsum >>> FracBits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) fv_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      fv_r[0] <= vld[BISECT_STEPS];
      for (int i = 1; i < 4; i++) fv_r[i] <= fv_r[i-1];
      out_valid_r <= fv_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sh > sum_t'(32'sh7FFFFFFF)) begin
        out_val_r <= 32'sh7FFFFFFF;
      end else if (sh < -sum_t'(64'sd2147483648)) begin
        out_val_r <= 32'sh80000000;
      end else begin
        out_val_r <= sh[CoordW-1:0];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_curve_value = out_val_r;
endmodule

@@ tb/cbz_checker.sv @@
module cbz_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  cbz_pkg::coord_t in_query_time,
  input  cbz_pkg::coord_t in_p0_time,
  input  cbz_pkg::coord_t in_p0_value,
  input  cbz_pkg::coord_t in_p1_time,
  input  cbz_pkg::coord_t in_p1_value,
  input  cbz_pkg::coord_t in_p2_time,
  input  cbz_pkg::coord_t in_p2_value,
  input  cbz_pkg::coord_t in_p3_time,
  input  cbz_pkg::coord_t in_p3_value,
  input  logic            out_valid,
  input  logic            out_stall,
  input  cbz_pkg::coord_t out_curve_value,
  output int              fail_count,
  output int              pending
);
  import cbz_pkg::*;

  localparam int Steps = 20;

  coord_t value_queue[$];

  function automatic longint weighted_sum(longint unsigned u, longint c0, longint c1,
                                          longint c2, longint c3);
    longint unsigned ot, a2, a3, b2, b3, w1, w2;
    ot = (64'd1 << FracBits) - u;
    a2 = (ot * ot) >> FracBits;
    a3 = (a2 * ot) >> FracBits;
    b2 = (u * u) >> FracBits;
    b3 = (b2 * u) >> FracBits;
    w1 = 3 * ((a2 * u) >> FracBits);
    w2 = 3 * ((ot * b2) >> FracBits);
    return c0 * longint'(a3) + c1 * longint'(w1) + c2 * longint'(w2) + c3 * longint'(b3);
  endfunction

  function automatic coord_t curve_value_at(coord_t q, coord_t t0, coord_t v0, coord_t t1,
                                           coord_t v1, coord_t t2, coord_t v2,
                                           coord_t t3, coord_t v3);
    longint unsigned lo, hi, u;
    longint target, s;
    lo = 0;
    hi = 64'd1 << FracBits;
    target = longint'(q) <<< FracBits;
    for (int i = 0; i < Steps; i++) begin
      u = (lo + hi) >> 1;
      if (weighted_sum(u, t0, t1, t2, t3) < target) lo = u;
      else hi = u;
    end
    u = (lo + hi) >> 1;
    s = weighted_sum(u, v0, v1, v2, v3) >>> FracBits;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return coord_t'(s);
  endfunction

  initial fail_count = 0;
  assign pending = value_queue.size();

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      value_queue.push_back(curve_value_at(in_query_time, in_p0_time, in_p0_value,
                                           in_p1_time, in_p1_value, in_p2_time,
                                           in_p2_value, in_p3_time, in_p3_value));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (value_queue.size() == 0) begin
        $error("unexpected result curve_value %0d", out_curve_value);
        fail_count <= fail_count + 1;
      end else if (value_queue[0] !== out_curve_value) begin
        $error("curve_value expected %0d actual %0d", value_queue[0], out_curve_value);
        fail_count <= fail_count + 1;
        void'(value_queue.pop_front());
      end else begin
        void'(value_queue.pop_front());
      end
    end
  end
endmodule

@@ tb/tb.sv @@
module tb;
  import cbz_pkg::*;

  localparam int Latency = 4 * 20 + 5;
  localparam int WatchLimit = 2000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 0;
  coord_t out_curve_value;
  coord_t q = 0, t0 = 0, v0 = 0, t1 = 0, v1 = 0, t2 = 0, v2 = 0, t3 = 0, v3 = 0;
  int fail_count, pending, idle_cycles;
  int stall_left = 0;

  always #5 clk = ~clk;

  cubic_bezier_time_curve_eval i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_query_time(q), .in_p0_time(t0), .in_p0_value(v0), .in_p1_time(t1),
    .in_p1_value(v1), .in_p2_time(t2), .in_p2_value(v2), .in_p3_time(t3),
    .in_p3_value(v3), .out_valid(out_valid), .out_stall(out_stall),
    .out_curve_value(out_curve_value)
  );

  cbz_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_query_time(q), .in_p0_time(t0), .in_p0_value(v0), .in_p1_time(t1),
    .in_p1_value(v1), .in_p2_time(t2), .in_p2_value(v2), .in_p3_time(t3),
    .in_p3_value(v3), .out_valid(out_valid), .out_stall(out_stall),
    .out_curve_value(out_curve_value), .fail_count(fail_count), .pending(pending)
  );

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return coord_t'($urandom_range(0, 32'h20000));
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_request(coord_t nq, coord_t nt0, coord_t nv0, coord_t nt1, coord_t nv1,
                              coord_t nt2, coord_t nv2, coord_t nt3, coord_t nv3);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    q <= nq; t0 <= nt0; v0 <= nv0; t1 <= nt1; v1 <= nv1;
    t2 <= nt2; v2 <= nv2; t3 <= nt3; v3 <= nv3;
    do @(posedge clk); while (in_stall);
  endtask

  // Well-formed segments have end times around a query inside them; inner times lie between, unordered.
  task automatic send_segment();
    int unsigned base, span;
    coord_t ts, te;
    base = $urandom_range(0, 32'h00400000);
    span = $urandom_range(1, 32'h00100000);
    ts = coord_t'(base) - 32'sh00200000;
    te = ts + coord_t'(span);
    send_request(ts + coord_t'($urandom_range(0, span)), ts, pick_coord(),
                 ts + coord_t'($urandom_range(0, span)), pick_coord(),
                 ts + coord_t'($urandom_range(0, span)), pick_coord(), te, pick_coord());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_request(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(32'sh8000, 0, 0, 32'sh4000, 32'sh10000, 32'shc000, 32'sh10000,
                 32'sh10000, 32'sh10000);
    send_request(32'sh7fffffff, 0, 32'sh7fffffff, 0, 32'sh7fffffff, 0, 32'sh7fffffff,
                 0, 32'sh7fffffff);
    send_request(32'sh80000000, 0, 32'sh80000000, 0, 32'sh80000000, 0, 32'sh80000000,
                 0, 32'sh80000000);
    send_request(0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_request(32'sh10000, 32'sh20000, 1, 32'sh30000, 2, 32'sh40000, 3, 32'sh50000, 4);
    send_request(32'sh50000, 0, -1, 32'sh10000, -1, 32'sh20000, -1, 32'sh30000, -1);
    send_request(32'sh8000, 32'sh10000, 32'sh10000, 0, 0, 32'sh10000, 32'sh10000, 0, 0);
    send_request(32'shffffffff, 32'shffffffff, 32'sh55555555, 32'shffffffff, 32'shaaaaaaaa,
                 32'shffffffff, 32'sh55555555, 32'shffffffff, 32'shaaaaaaaa);
    for (int i = 0; i < 950; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_request(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), pick_coord(), pick_coord());
      end else begin
        send_segment();
      end
    end
    in_valid <= 0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      stall_left = $urandom_range(0, 7);
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end
endmodule
